// ----- rtl/fdr_pkg.sv -----
// Shared widths and constants for the Fresnel dielectric reflectance core.
`default_nettype none
package fdr_pkg;
    localparam int COS_W  = 16;
    localparam int ETA_W  = 16;
    localparam int REFL_W = 16;
    localparam logic [REFL_W-1:0] REFL_ONE = 16'h8000;
    typedef logic [ETA_W-1:0] eta_t;
endpackage
`default_nettype wire

// ----- rtl/fdr_sqrt_pipe.sv -----
// Pipelined integer square root, one result bit per register stage.
`default_nettype none
module fdr_sqrt_pipe
    import fdr_pkg::*;
#(
    parameter int RW = 31,
    parameter int RB = 16,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [RW-1:0] in_rad,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [RB-1:0]      out_root,
    output logic [SW-1:0]      out_side
);
    logic [RW-1:0] st_rem  [0:RB];
    logic [RW-1:0] st_res  [0:RB];
    logic [SW-1:0] st_side [0:RB];
    logic          st_v    [0:RB];

    assign st_rem[0]  = in_rad;
    assign st_res[0]  = '0;
    assign st_side[0] = in_side;
    assign st_v[0]    = in_valid;

    for (genvar j = 0; j < RB; j++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (RB - 1 - j));
        logic [RW-1:0] rem_reg, res_reg, rem_next, res_next, sum;
        logic [SW-1:0] side_reg;
        logic          v_reg;

        always_comb begin
            sum = st_res[j] + BIT;
            if (st_rem[j] >= sum) begin
                rem_next = st_rem[j] - sum;
                res_next = (st_res[j] >> 1) + BIT;
            end else begin
                rem_next = st_rem[j];
                res_next = st_res[j] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= st_v[j];
            end
            if (en) begin
                rem_reg  <= rem_next;
                res_reg  <= res_next;
                side_reg <= st_side[j];
            end
        end

        assign st_rem[j+1]  = rem_reg;
        assign st_res[j+1]  = res_reg;
        assign st_side[j+1] = side_reg;
        assign st_v[j+1]    = v_reg;
    end

    assign out_valid = st_v[RB];
    assign out_root  = st_res[RB][RB-1:0];
    assign out_side  = st_side[RB];
endmodule
`default_nettype wire

// ----- rtl/fdr_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
`default_nettype none
module fdr_div_pipe
    import fdr_pkg::*;
#(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QB = 15,
    parameter int SW = 1
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          en,
    input  wire logic          in_valid,
    input  wire logic [NW-1:0] in_num,
    input  wire logic [DW-1:0] in_den,
    input  wire logic [SW-1:0] in_side,
    output logic               out_valid,
    output logic [QB-1:0]      out_quot,
    output logic [SW-1:0]      out_side
);
    localparam int IW = (NW > DW + QB) ? NW : DW + QB;

    logic [IW-1:0] st_rem  [0:QB];
    logic [DW-1:0] st_den  [0:QB];
    logic [QB-1:0] st_q    [0:QB];
    logic [SW-1:0] st_side [0:QB];
    logic          st_v    [0:QB];

    assign st_rem[0]  = IW'(in_num);
    assign st_den[0]  = in_den;
    assign st_q[0]    = '0;
    assign st_side[0] = in_side;
    assign st_v[0]    = in_valid;

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int K = QB - 1 - j;
        logic [IW-1:0] rem_reg, rem_next, trial;
        logic [DW-1:0] den_reg;
        logic [QB-1:0] q_reg, q_next;
        logic [SW-1:0] side_reg;
        logic          v_reg;

        always_comb begin
            trial    = IW'(st_den[j]) << K;
            rem_next = st_rem[j];
            q_next   = st_q[j];
            if (st_rem[j] >= trial) begin
                rem_next  = st_rem[j] - trial;
                q_next[K] = 1'b1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= st_v[j];
            end
            if (en) begin
                rem_reg  <= rem_next;
                den_reg  <= st_den[j];
                q_reg    <= q_next;
                side_reg <= st_side[j];
            end
        end

        assign st_rem[j+1]  = rem_reg;
        assign st_den[j+1]  = den_reg;
        assign st_q[j+1]    = q_reg;
        assign st_side[j+1] = side_reg;
        assign st_v[j+1]    = v_reg;
    end

    assign out_valid = st_v[QB];
    assign out_quot  = st_q[QB];
    assign out_side  = st_side[QB];
endmodule
`default_nettype wire

// ----- rtl/fresnel_dielectric_reflectance_core.sv -----
// Top level of the pipelined unpolarized Fresnel dielectric reflectance core.
//
//  Channel | Direction | Ports                                                  | Handshake
//  input   | in        | s_cos_incident, s_eta_incident, s_eta_transmitted      | s_valid/s_ready
//  result  | out       | m_reflectance, m_total_reflection                      | m_valid/m_ready
//
// One transfer enters per cycle while the pipeline does not stall. The pipeline holds two
// square root pipelines of FRAC_BITS+1 stages, two dividers of FRAC_BITS stages in series
// (the perpendicular divider runs beside the parallel one), and eight single register
// stages, the output register among them.
// The whole pipeline advances together; it stalls only while the output register holds
// a result that is not taken. Reset (aresetn low, synchronous) clears all valid bits.
`default_nettype none
module fresnel_dielectric_reflectance_core
    import fdr_pkg::*;
#(
    parameter int FRAC_BITS = 15
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [COS_W-1:0] s_cos_incident,
    input  wire logic [ETA_W-1:0]  s_eta_incident,
    input  wire logic [ETA_W-1:0]  s_eta_transmitted,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [REFL_W-1:0]      m_reflectance,
    output logic                   m_total_reflection
);
    localparam int F    = FRAC_BITS;
    localparam int CW   = F + 1;          // cosine/sine, up to 1.0
    localparam int RW   = 2 * F + 1;      // radicand, up to 1.0 squared
    localparam int NUMW = ETA_W + CW;     // index times sine or cosine
    localparam int DW2  = NUMW + 1;       // ratio denominator
    localparam int N2W  = NUMW + F;       // ratio numerator after scaling
    localparam int SQW  = F + 1;          // squared ratio, up to 1.0
    localparam int TW   = F + 2;          // sum of both squares
    localparam int RESW = F + 8;          // rescaled sum before saturation
    localparam logic [RW-1:0]  RAD_ONE = RW'(1) << (2 * F);
    localparam logic [SQW-1:0] SQ_ONE  = SQW'(1) << F;

    // The whole pipeline moves when the output register is free or being emptied.
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Stage 1: sign decode, index swap for rays leaving the medium, cosine rescale.
    logic          neg, entering;
    logic [16:0]   mag;
    logic [CW-1:0] ci_next;
    eta_t          ei_next, et_next;

    always_comb begin
        neg      = s_cos_incident[COS_W-1];
        entering = !neg && (s_cos_incident != '0);
        mag      = neg ? (17'h10000 - {1'b0, s_cos_incident}) : {1'b0, s_cos_incident};
        ei_next  = entering ? s_eta_incident : s_eta_transmitted;
        et_next  = entering ? s_eta_transmitted : s_eta_incident;
    end

    if (F >= 15) begin : g_ci_up
        assign ci_next = CW'(mag) << (F - 15);
    end else begin : g_ci_dn
        logic [17:0] rnd;
        assign rnd     = {1'b0, mag} + (18'd1 << (14 - F));
        assign ci_next = CW'(rnd >> (15 - F));
    end

    logic          v1_reg;
    logic [CW-1:0] ci1_reg;
    eta_t          ei1_reg, et1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_valid;
        end
        if (en) begin
            ci1_reg <= ci_next;
            ei1_reg <= ei_next;
            et1_reg <= et_next;
        end
    end

    // Stage 2: radicand for the incident sine, 1 - cos^2.
    logic          v2_reg;
    logic [RW-1:0] rad1_reg, rad1_next;
    logic [CW-1:0] ci2_reg;
    eta_t          ei2_reg, et2_reg;
    logic [2*CW-1:0] ci_sq;

    assign ci_sq     = ci1_reg * ci1_reg;
    assign rad1_next = RAD_ONE - RW'(ci_sq);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            rad1_reg <= rad1_next;
            ci2_reg  <= ci1_reg;
            ei2_reg  <= ei1_reg;
            et2_reg  <= et1_reg;
        end
    end

    // Incident sine.
    logic          sq1_v;
    logic [CW-1:0] sini;
    logic [CW+2*ETA_W-1:0] sq1_side;

    fdr_sqrt_pipe #(.RW(RW), .RB(CW), .SW(CW + 2 * ETA_W)) u_sqrt_sin (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v2_reg),
        .in_rad    (rad1_reg),
        .in_side   ({ci2_reg, ei2_reg, et2_reg}),
        .out_valid (sq1_v),
        .out_root  (sini),
        .out_side  (sq1_side)
    );

    // Stage 3: scaled transmitted sine numerator and total internal reflection test.
    logic            v3_reg, tir3_reg, tir3_next;
    logic [NUMW-1:0] num3_reg, num3_next;
    logic [CW-1:0]   ci3_reg;
    eta_t            ei3_reg, et3_reg, ei_s, et_s;
    logic [CW-1:0]   ci_s;

    always_comb begin
        {ci_s, ei_s, et_s} = sq1_side;
        num3_next = NUMW'(ei_s) * NUMW'(sini);
        tir3_next = (et_s == '0) || (num3_next >= (NUMW'(et_s) << F));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= sq1_v;
        end
        if (en) begin
            num3_reg <= num3_next;
            tir3_reg <= tir3_next;
            ci3_reg  <= ci_s;
            ei3_reg  <= ei_s;
            et3_reg  <= et_s;
        end
    end

    // Transmitted sine, ei*sin_i / et.
    logic          dv1_v;
    logic [F-1:0]  sint;
    logic [CW+2*ETA_W:0] dv1_side;

    fdr_div_pipe #(.NW(NUMW), .DW(ETA_W), .QB(F), .SW(CW + 2 * ETA_W + 1)) u_div_sint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_num    (num3_reg),
        .in_den    (et3_reg),
        .in_side   ({tir3_reg, ci3_reg, ei3_reg, et3_reg}),
        .out_valid (dv1_v),
        .out_quot  (sint),
        .out_side  (dv1_side)
    );

    // Stage 4: radicand for the transmitted cosine, 1 - sin_t^2.
    logic          v4_reg;
    logic [RW-1:0] rad2_reg;
    logic [2*F-1:0] sint_sq;
    logic [CW+2*ETA_W:0] side4_reg;

    assign sint_sq = sint * sint;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= dv1_v;
        end
        if (en) begin
            rad2_reg  <= RAD_ONE - RW'(sint_sq);
            side4_reg <= dv1_side;
        end
    end

    // Transmitted cosine.
    logic          sq2_v;
    logic [CW-1:0] ct;
    logic [CW+2*ETA_W:0] sq2_side;

    fdr_sqrt_pipe #(.RW(RW), .RB(CW), .SW(CW + 2 * ETA_W + 1)) u_sqrt_cos (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_rad    (rad2_reg),
        .in_side   (side4_reg),
        .out_valid (sq2_v),
        .out_root  (ct),
        .out_side  (sq2_side)
    );

    // Stage 5: the four index-angle products.
    logic            v5_reg, tir5_reg, tir_s5;
    logic [NUMW-1:0] a1_reg, b1_reg, a2_reg, b2_reg;
    logic [CW-1:0]   ci_s5;
    eta_t            ei_s5, et_s5;

    assign {tir_s5, ci_s5, ei_s5, et_s5} = sq2_side;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= sq2_v;
        end
        if (en) begin
            tir5_reg <= tir_s5;
            a1_reg   <= NUMW'(et_s5) * NUMW'(ci_s5);
            b1_reg   <= NUMW'(ei_s5) * NUMW'(ct);
            a2_reg   <= NUMW'(ei_s5) * NUMW'(ci_s5);
            b2_reg   <= NUMW'(et_s5) * NUMW'(ct);
        end
    end

    // Stage 6: ratio numerators and denominators for the parallel and
    // perpendicular terms; a zero or degenerate denominator forces the term to 1.0.
    logic            v6_reg, tir6_reg, one1_reg, one2_reg;
    logic [DW2-1:0]  d1_reg, d2_reg, d1, d2;
    logic [N2W-1:0]  n1_reg, n2_reg;
    logic [NUMW-1:0] df1, df2;

    always_comb begin
        d1  = DW2'(a1_reg) + DW2'(b1_reg);
        d2  = DW2'(a2_reg) + DW2'(b2_reg);
        df1 = (a1_reg > b1_reg) ? (a1_reg - b1_reg) : (b1_reg - a1_reg);
        df2 = (a2_reg > b2_reg) ? (a2_reg - b2_reg) : (b2_reg - a2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
        if (en) begin
            tir6_reg <= tir5_reg;
            d1_reg   <= d1;
            d2_reg   <= d2;
            n1_reg   <= N2W'(df1) << F;
            n2_reg   <= N2W'(df2) << F;
            one1_reg <= (d1 == '0) || (DW2'(df1) >= d1);
            one2_reg <= (d2 == '0) || (DW2'(df2) >= d2);
        end
    end

    // Both ratios, in parallel dividers.
    logic         dv2_v, dv3_v, dv3_side;
    logic [F-1:0] q1, q2;
    logic [1:0]   dv2_side;

    fdr_div_pipe #(.NW(N2W), .DW(DW2), .QB(F), .SW(2)) u_div_parl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    (n1_reg),
        .in_den    (d1_reg),
        .in_side   ({tir6_reg, one1_reg}),
        .out_valid (dv2_v),
        .out_quot  (q1),
        .out_side  (dv2_side)
    );

    fdr_div_pipe #(.NW(N2W), .DW(DW2), .QB(F), .SW(1)) u_div_perp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v6_reg),
        .in_num    (n2_reg),
        .in_den    (d2_reg),
        .in_side   (one2_reg),
        .out_valid (dv3_v),
        .out_quot  (q2),
        .out_side  (dv3_side)
    );

    // Stage 7: square each ratio.
    logic           v7_reg, tir7_reg;
    logic [SQW-1:0] s1_reg, s2_reg;
    logic [2*F-1:0] q1_sq, q2_sq;

    assign q1_sq = q1 * q1;
    assign q2_sq = q2 * q2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            // Both dividers advance in lockstep, so their valid bits always agree.
            v7_reg <= dv2_v && dv3_v;
        end
        if (en) begin
            tir7_reg <= dv2_side[1];
            s1_reg   <= dv2_side[0] ? SQ_ONE : SQW'(q1_sq >> F);
            s2_reg   <= dv3_side ? SQ_ONE : SQW'(q2_sq >> F);
        end
    end

    // Stage 8: halve the sum and rescale to Q1.15 with round half up, then saturate.
    logic [TW-1:0]   total;
    logic [RESW-1:0] tot_ext, res;
    logic [REFL_W-1:0] refl_next;

    assign total   = TW'(s1_reg) + TW'(s2_reg);
    assign tot_ext = RESW'(total);

    if (F > 14) begin : g_rnd
        assign res = (tot_ext + (RESW'(1) << (F - 15))) >> (F - 14);
    end else if (F == 14) begin : g_same
        assign res = tot_ext;
    end else begin : g_up
        assign res = tot_ext << (14 - F);
    end

    always_comb begin
        if (tir7_reg || (res > RESW'(REFL_ONE))) begin
            refl_next = REFL_ONE;
        end else begin
            refl_next = res[REFL_W-1:0];
        end
    end

    logic              m_valid_reg, m_tir_reg;
    logic [REFL_W-1:0] m_refl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= v7_reg;
        end
        if (en) begin
            m_refl_reg <= refl_next;
            m_tir_reg  <= tir7_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_reflectance      = m_refl_reg;
    assign m_total_reflection = m_tir_reg;

`ifndef SYNTH
    // Total internal reflection always reports full reflectance.
    a_tir_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_total_reflection) |-> (m_reflectance == REFL_ONE))
        else $error("total reflection without full reflectance");

    // The result never exceeds 1.0.
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reflectance <= REFL_ONE))
        else $error("reflectance above saturation");

    // A held result keeps the pipeline frozen, so neither the output nor the stage feeding it may move.
    a_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> ($stable(m_reflectance) && $stable(v7_reg)))
        else $error("pipeline moved while the output was stalled");
`endif
endmodule
`default_nettype wire
